// ----- rtl/pgts_pkg.sv -----
`default_nettype none
package pgts_pkg;

   localparam int MAX_DIM   = 16;
   localparam int FRAC_BITS = 8;
   localparam int NUM_FACES = 6;
   localparam int POS_W     = 12;
   localparam int COLOR_W   = 8;
   localparam int FACE_W    = 3;
   localparam int DIM_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int LANES     = 3;

   localparam int CRD_W     = $clog2(MAX_DIM);
   localparam int DEPTH     = MAX_DIM * MAX_DIM * MAX_DIM * NUM_FACES;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int RAM_W     = LANES * COLOR_W;
   localparam int CMP_W     = POS_W;
   localparam int WGT_W     = FRAC_BITS + 1;
   localparam int OP_W      = COLOR_W + FRAC_BITS;
   localparam int ACC_W     = OP_W + WGT_W;
   localparam int SEQ_STEPS = 14;
   localparam int STEP_W    = $clog2(SEQ_STEPS);

   localparam logic [WGT_W-1:0]   ONE_FX     = WGT_W'(1) << FRAC_BITS;
   localparam logic [DIM_W-1:0]   GRID_RESET = DIM_W'(16);
   localparam logic [FACE_W-1:0]  LAST_FACE  = FACE_W'(NUM_FACES - 1);
   localparam logic [COLOR_W-1:0] COLOR_MAX  = '1;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_DEPTH  = CSR_IDX_W'(2);

   // face mac steps: corner pairs, y blends between, z blend last
   localparam logic [STEP_W-1:0] SEQ_A0  = STEP_W'(0);
   localparam logic [STEP_W-1:0] SEQ_A1  = STEP_W'(1);
   localparam logic [STEP_W-1:0] SEQ_B0  = STEP_W'(2);
   localparam logic [STEP_W-1:0] SEQ_B1  = STEP_W'(3);
   localparam logic [STEP_W-1:0] SEQ_LO0 = STEP_W'(4);
   localparam logic [STEP_W-1:0] SEQ_LO1 = STEP_W'(5);
   localparam logic [STEP_W-1:0] SEQ_C0  = STEP_W'(6);
   localparam logic [STEP_W-1:0] SEQ_C1  = STEP_W'(7);
   localparam logic [STEP_W-1:0] SEQ_E0  = STEP_W'(8);
   localparam logic [STEP_W-1:0] SEQ_E1  = STEP_W'(9);
   localparam logic [STEP_W-1:0] SEQ_HI0 = STEP_W'(10);
   localparam logic [STEP_W-1:0] SEQ_HI1 = STEP_W'(11);
   localparam logic [STEP_W-1:0] SEQ_V0  = STEP_W'(12);
   localparam logic [STEP_W-1:0] SEQ_V1  = STEP_W'(13);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_OUT
   } pgts_state_type;

   typedef struct packed {
      logic               opcode;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_z;
      logic [FACE_W-1:0]  face_sel;
      logic [COLOR_W-1:0] red_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] blue_in;
   } pgts_req_type;

   typedef struct packed {
      logic [FACE_W-1:0]  face_out;
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
      logic               in_range;
      logic               last_face;
   } pgts_rsp_type;

   typedef struct packed {
      logic             en;
      logic             first;
      logic [WGT_W-1:0] weight;
   } pgts_mac_ctl_type;

   function automatic logic [ADDR_W-1:0] cell_addr(
      input logic [CRD_W-1:0]  x,
      input logic [CRD_W-1:0]  y,
      input logic [CRD_W-1:0]  z,
      input logic [FACE_W-1:0] face
   );
      logic [ADDR_W-1:0] lin_idx;
      lin_idx = ADDR_W'(z) * ADDR_W'(MAX_DIM * MAX_DIM) + ADDR_W'(y) * ADDR_W'(MAX_DIM)
                + ADDR_W'(x);
      return lin_idx * ADDR_W'(NUM_FACES) + ADDR_W'(face);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/pgts_ram.sv -----
`default_nettype none
module pgts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/pgts_mac.sv -----
`default_nettype none
module pgts_mac (
   input  wire logic                                         clock,
   input  wire pgts_pkg::pgts_mac_ctl_type                   ctl,
   input  wire logic [pgts_pkg::LANES-1:0][pgts_pkg::OP_W-1:0]  op,
   output logic      [pgts_pkg::LANES-1:0][pgts_pkg::ACC_W-1:0] acc
);

   logic [pgts_pkg::LANES-1:0][pgts_pkg::ACC_W-1:0] acc_ff;
   logic [pgts_pkg::LANES-1:0][pgts_pkg::ACC_W-1:0] acc_in;

   always_comb begin
      for (int i = 0; i < pgts_pkg::LANES; i++) begin
         acc_in[i] = (ctl.first ? '0 : acc_ff[i])
                     + pgts_pkg::ACC_W'(op[i]) * pgts_pkg::ACC_W'(ctl.weight);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

// ----- rtl/probe_grid_trilinear_sampler.sv -----
// Probe grid trilinear sampler.
// Input channel req_valid/req_ready/req_data carries one word per operation. A write
// word (opcode 0) stores one face color of the probe at the integer cell of its
// coordinates and gives no result. A sample word (opcode 1) gives six result words
// on rsp_valid/rsp_ready/rsp_data, one per face, the last one flagged by last_face,
// or a single word with in_range low when the cell lies outside the grid.
// Each face runs 14 multiply-accumulate steps on one three-lane mac (one per color
// channel), fed from one probe memory read port: a load state, then the 14 steps,
// then the result word; each further face starts only after the previous one is
// taken. An out-of-range sample answers in the cycle after it is taken.
// req_ready is low from the time a sample is taken until its last word is taken;
// while rsp_ready is low the result word holds and the sequencer waits.
// csr_we/csr_index/csr_wdata write grid_width, grid_height and grid_depth; write them
// only while idle. Reset sets all three to 16 and returns to idle; probe memory is
// not cleared and every sampled entry must be written first.
`default_nettype none
module probe_grid_trilinear_sampler (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire pgts_pkg::pgts_req_type            req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output pgts_pkg::pgts_rsp_type                 rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [pgts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pgts_pkg::DIM_W-1:0]        csr_wdata
);

   localparam int VTOP_W = pgts_pkg::ACC_W - 2 * pgts_pkg::FRAC_BITS;

   function automatic logic [pgts_pkg::DIM_W-1:0] eff_dim(
      input logic [pgts_pkg::DIM_W-1:0] dim
   );
      if (pgts_pkg::CMP_W'(dim) > pgts_pkg::CMP_W'(pgts_pkg::MAX_DIM)) begin
         return pgts_pkg::DIM_W'(pgts_pkg::MAX_DIM);
      end
      return dim;
   endfunction

   pgts_pkg::pgts_state_type state_ff, state_in;
   logic [pgts_pkg::STEP_W-1:0] step_ff, step_in;
   logic [pgts_pkg::FACE_W-1:0] face_ff, face_in;
   logic                        oor_ff, oor_in;

   logic [pgts_pkg::DIM_W-1:0] grid_w_ff, grid_h_ff, grid_d_ff;
   logic [pgts_pkg::DIM_W-1:0] w_eff, h_eff, d_eff;

   logic [pgts_pkg::CRD_W-1:0] cx_ff, cy_ff, cz_ff, x1_ff, y1_ff, z1_ff;
   logic [pgts_pkg::FRAC_BITS-1:0] fx_ff, fy_ff, fz_ff;
   logic [pgts_pkg::WGT_W-1:0]     gx_ff, gy_ff, gz_ff;

   logic [pgts_pkg::LANES-1:0][pgts_pkg::OP_W-1:0] a_ff, b_ff, c_ff, e_ff, lo_ff, hi_ff;

   logic req_accept, rsp_accept, is_sample, in_rng;
   logic [pgts_pkg::CMP_W-1:0] ix, iy, iz, nx, ny, nz, x1, y1, z1;
   logic [pgts_pkg::FRAC_BITS-1:0] fx, fy, fz;

   logic                           wr_en;
   logic [pgts_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
   logic [pgts_pkg::RAM_W-1:0]     wr_data, rd_data;
   logic [pgts_pkg::STEP_W-1:0]    rd_step;
   logic                           sel_x1, sel_y1, sel_z1;

   pgts_pkg::pgts_mac_ctl_type                      mac_ctl;
   logic [pgts_pkg::LANES-1:0][pgts_pkg::OP_W-1:0]  mac_op, ram_lane;
   logic [pgts_pkg::LANES-1:0][pgts_pkg::ACC_W-1:0] mac_acc;
   logic [pgts_pkg::LANES-1:0][pgts_pkg::COLOR_W-1:0] color;
   logic [VTOP_W-1:0] v_top;

   // sample decode
   always_comb begin
      w_eff = eff_dim(grid_w_ff);
      h_eff = eff_dim(grid_h_ff);
      d_eff = eff_dim(grid_d_ff);
      ix = req_data.pos_x >> pgts_pkg::FRAC_BITS;
      iy = req_data.pos_y >> pgts_pkg::FRAC_BITS;
      iz = req_data.pos_z >> pgts_pkg::FRAC_BITS;
      fx = pgts_pkg::FRAC_BITS'(req_data.pos_x);
      fy = pgts_pkg::FRAC_BITS'(req_data.pos_y);
      fz = pgts_pkg::FRAC_BITS'(req_data.pos_z);
      in_rng = (ix < pgts_pkg::CMP_W'(w_eff)) && (iy < pgts_pkg::CMP_W'(h_eff))
               && (iz < pgts_pkg::CMP_W'(d_eff));
      nx = ix + pgts_pkg::CMP_W'(1);
      ny = iy + pgts_pkg::CMP_W'(1);
      nz = iz + pgts_pkg::CMP_W'(1);
      x1 = (nx < pgts_pkg::CMP_W'(w_eff)) ? nx : pgts_pkg::CMP_W'(w_eff) - pgts_pkg::CMP_W'(1);
      y1 = (ny < pgts_pkg::CMP_W'(h_eff)) ? ny : pgts_pkg::CMP_W'(h_eff) - pgts_pkg::CMP_W'(1);
      z1 = (nz < pgts_pkg::CMP_W'(d_eff)) ? nz : pgts_pkg::CMP_W'(d_eff) - pgts_pkg::CMP_W'(1);
   end

   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;
   assign is_sample  = req_data.opcode == pgts_pkg::OP_SAMPLE;

   // probe writes
   assign wr_en = req_accept && (req_data.opcode == pgts_pkg::OP_WRITE) && in_rng
                  && (pgts_pkg::CMP_W'(req_data.face_sel) < pgts_pkg::CMP_W'(pgts_pkg::NUM_FACES));
   assign wr_addr = pgts_pkg::cell_addr(pgts_pkg::CRD_W'(ix), pgts_pkg::CRD_W'(iy),
                                        pgts_pkg::CRD_W'(iz), req_data.face_sel);
   assign wr_data = {req_data.red_in, req_data.green_in, req_data.blue_in};

   // corner read for the step after the current one
   always_comb begin
      rd_step = (state_ff == pgts_pkg::ST_LOAD) ? pgts_pkg::SEQ_A0
                                                : step_ff + pgts_pkg::STEP_W'(1);
      sel_x1 = 1'b0;
      sel_y1 = 1'b0;
      sel_z1 = 1'b0;
      unique case (rd_step)
         pgts_pkg::SEQ_A1: begin
            sel_x1 = 1'b1;
         end
         pgts_pkg::SEQ_B0: begin
            sel_y1 = 1'b1;
         end
         pgts_pkg::SEQ_B1: begin
            sel_x1 = 1'b1;
            sel_y1 = 1'b1;
         end
         pgts_pkg::SEQ_C0: begin
            sel_z1 = 1'b1;
         end
         pgts_pkg::SEQ_C1: begin
            sel_x1 = 1'b1;
            sel_z1 = 1'b1;
         end
         pgts_pkg::SEQ_E0: begin
            sel_y1 = 1'b1;
            sel_z1 = 1'b1;
         end
         pgts_pkg::SEQ_E1: begin
            sel_x1 = 1'b1;
            sel_y1 = 1'b1;
            sel_z1 = 1'b1;
         end
         default: begin
         end
      endcase
      rd_addr = pgts_pkg::cell_addr(sel_x1 ? x1_ff : cx_ff, sel_y1 ? y1_ff : cy_ff,
                                    sel_z1 ? z1_ff : cz_ff, face_ff);
   end

   pgts_ram #(
      .WIDTH (pgts_pkg::RAM_W),
      .DEPTH (pgts_pkg::DEPTH)
   ) u_probe_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // mac operand and weight select
   always_comb begin
      for (int i = 0; i < pgts_pkg::LANES; i++) begin
         ram_lane[i] = pgts_pkg::OP_W'(
            rd_data[pgts_pkg::COLOR_W*(pgts_pkg::LANES-1-i) +: pgts_pkg::COLOR_W]);
      end
      mac_ctl.en     = state_ff == pgts_pkg::ST_RUN;
      mac_ctl.first  = 1'b0;
      mac_ctl.weight = '0;
      mac_op         = '0;
      unique case (step_ff)
         pgts_pkg::SEQ_A0, pgts_pkg::SEQ_B0, pgts_pkg::SEQ_C0, pgts_pkg::SEQ_E0: begin
            mac_ctl.first  = 1'b1;
            mac_ctl.weight = gx_ff;
            mac_op         = ram_lane;
         end
         pgts_pkg::SEQ_A1, pgts_pkg::SEQ_B1, pgts_pkg::SEQ_C1, pgts_pkg::SEQ_E1: begin
            mac_ctl.weight = pgts_pkg::WGT_W'(fx_ff);
            mac_op         = ram_lane;
         end
         pgts_pkg::SEQ_LO0: begin
            mac_ctl.first  = 1'b1;
            mac_ctl.weight = gy_ff;
            mac_op         = a_ff;
         end
         pgts_pkg::SEQ_LO1: begin
            mac_ctl.weight = pgts_pkg::WGT_W'(fy_ff);
            mac_op         = b_ff;
         end
         pgts_pkg::SEQ_HI0: begin
            mac_ctl.first  = 1'b1;
            mac_ctl.weight = gy_ff;
            mac_op         = c_ff;
         end
         pgts_pkg::SEQ_HI1: begin
            mac_ctl.weight = pgts_pkg::WGT_W'(fy_ff);
            mac_op         = e_ff;
         end
         pgts_pkg::SEQ_V0: begin
            mac_ctl.first  = 1'b1;
            mac_ctl.weight = gz_ff;
            mac_op         = lo_ff;
         end
         pgts_pkg::SEQ_V1: begin
            mac_ctl.weight = pgts_pkg::WGT_W'(fz_ff);
            mac_op         = hi_ff;
         end
         default: begin
         end
      endcase
   end

   pgts_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op    (mac_op),
      .acc   (mac_acc)
   );

   // partial blends, taken in the step after the mac produced them
   always_ff @(posedge clock) begin
      if (state_ff == pgts_pkg::ST_RUN) begin
         for (int i = 0; i < pgts_pkg::LANES; i++) begin
            unique case (step_ff)
               pgts_pkg::SEQ_B0:  a_ff[i]  <= mac_acc[i][pgts_pkg::OP_W-1:0];
               pgts_pkg::SEQ_LO0: b_ff[i]  <= mac_acc[i][pgts_pkg::OP_W-1:0];
               pgts_pkg::SEQ_C0:  lo_ff[i] <= mac_acc[i][pgts_pkg::FRAC_BITS +: pgts_pkg::OP_W];
               pgts_pkg::SEQ_E0:  c_ff[i]  <= mac_acc[i][pgts_pkg::OP_W-1:0];
               pgts_pkg::SEQ_HI0: e_ff[i]  <= mac_acc[i][pgts_pkg::OP_W-1:0];
               pgts_pkg::SEQ_V0:  hi_ff[i] <= mac_acc[i][pgts_pkg::FRAC_BITS +: pgts_pkg::OP_W];
               default: begin
               end
            endcase
         end
      end
   end

   // sample coordinates and weights
   always_ff @(posedge clock) begin
      if (req_accept && is_sample) begin
         cx_ff <= pgts_pkg::CRD_W'(ix);
         cy_ff <= pgts_pkg::CRD_W'(iy);
         cz_ff <= pgts_pkg::CRD_W'(iz);
         x1_ff <= pgts_pkg::CRD_W'(x1);
         y1_ff <= pgts_pkg::CRD_W'(y1);
         z1_ff <= pgts_pkg::CRD_W'(z1);
         fx_ff <= fx;
         fy_ff <= fy;
         fz_ff <= fz;
         gx_ff <= pgts_pkg::ONE_FX - pgts_pkg::WGT_W'(fx);
         gy_ff <= pgts_pkg::ONE_FX - pgts_pkg::WGT_W'(fy);
         gz_ff <= pgts_pkg::ONE_FX - pgts_pkg::WGT_W'(fz);
      end
   end

   // control registers and grid configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pgts_pkg::ST_IDLE;
         step_ff   <= pgts_pkg::SEQ_A0;
         face_ff   <= '0;
         oor_ff    <= 1'b0;
         grid_w_ff <= pgts_pkg::GRID_RESET;
         grid_h_ff <= pgts_pkg::GRID_RESET;
         grid_d_ff <= pgts_pkg::GRID_RESET;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         face_ff  <= face_in;
         oor_ff   <= oor_in;
         if (csr_we) begin
            unique case (csr_index)
               pgts_pkg::CSR_GRID_WIDTH:  grid_w_ff <= csr_wdata;
               pgts_pkg::CSR_GRID_HEIGHT: grid_h_ff <= csr_wdata;
               pgts_pkg::CSR_GRID_DEPTH:  grid_d_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      face_in  = face_ff;
      oor_in   = oor_ff;
      unique case (state_ff)
         pgts_pkg::ST_IDLE: begin
            if (req_accept && is_sample) begin
               face_in = '0;
               oor_in  = !in_rng;
               state_in = in_rng ? pgts_pkg::ST_LOAD : pgts_pkg::ST_OUT;
            end
         end
         pgts_pkg::ST_LOAD: begin
            step_in  = pgts_pkg::SEQ_A0;
            state_in = pgts_pkg::ST_RUN;
         end
         pgts_pkg::ST_RUN: begin
            if (step_ff == pgts_pkg::SEQ_V1) begin
               state_in = pgts_pkg::ST_OUT;
            end else begin
               step_in = step_ff + pgts_pkg::STEP_W'(1);
            end
         end
         pgts_pkg::ST_OUT: begin
            if (rsp_accept) begin
               if (oor_ff || face_ff == pgts_pkg::LAST_FACE) begin
                  state_in = pgts_pkg::ST_IDLE;
               end else begin
                  face_in  = face_ff + pgts_pkg::FACE_W'(1);
                  state_in = pgts_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = pgts_pkg::ST_IDLE;
         end
      endcase
   end

   // final z blend, truncated and saturated
   always_comb begin
      v_top = '0;
      for (int i = 0; i < pgts_pkg::LANES; i++) begin
         v_top = mac_acc[i][pgts_pkg::ACC_W-1 : 2*pgts_pkg::FRAC_BITS];
         color[i] = (v_top > VTOP_W'(pgts_pkg::COLOR_MAX)) ? pgts_pkg::COLOR_MAX
                                                           : pgts_pkg::COLOR_W'(v_top);
      end
   end

   // outputs
   always_comb begin
      req_ready          = state_ff == pgts_pkg::ST_IDLE;
      rsp_valid          = state_ff == pgts_pkg::ST_OUT;
      rsp_data.face_out  = oor_ff ? '0 : face_ff;
      rsp_data.red_out   = oor_ff ? '0 : color[0];
      rsp_data.green_out = oor_ff ? '0 : color[1];
      rsp_data.blue_out  = oor_ff ? '0 : color[2];
      rsp_data.in_range  = !oor_ff;
      rsp_data.last_face = oor_ff || (face_ff == pgts_pkg::LAST_FACE);
   end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
   import pgts_pkg::*;

   localparam int unsigned DRAIN_CYCLES = 120;
   localparam int unsigned IDLE_LIMIT   = 4000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_TOGGLE
   } rx_mode_type;

   logic clock;
   logic reset;
   logic req_valid = 1'b0;
   logic req_ready;
   pgts_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pgts_rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0] csr_wdata;

   probe_grid_trilinear_sampler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // grid setting as the block sees it
   logic [DIM_W-1:0] grid_w = GRID_RESET;
   logic [DIM_W-1:0] grid_h = GRID_RESET;
   logic [DIM_W-1:0] grid_d = GRID_RESET;

   logic [RAM_W-1:0] probe_mem [DEPTH];
   bit filled [DEPTH];
   pgts_rsp_type face_color_q [$];
   pgts_req_type pending_words [$];

   int unsigned words_queued = 0;
   int unsigned burst_left, gap_left;
   int unsigned rx_cycle, hold_left, words_taken;
   int unsigned idle_cycles = 0;
   int unsigned fail_count = 0;
   int unsigned results_checked = 0;
   int unsigned samples_in = 0, samples_out = 0;
   int unsigned writes_stored = 0, writes_ignored = 0;
   pgts_rsp_type face_want;
   bit bad;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned span(input logic [DIM_W-1:0] r);
      return (r > MAX_DIM) ? MAX_DIM : r;
   endfunction

   function automatic bit cell_inside(input int unsigned cx, cy, cz);
      return cx < span(grid_w) && cy < span(grid_h) && cz < span(grid_d);
   endfunction

   function automatic int unsigned probe_index(input int unsigned x, y, z, f);
      return ((z * MAX_DIM + y) * MAX_DIM + x) * NUM_FACES + f;
   endfunction

   function automatic int unsigned probe_chan(input int unsigned x, y, z, f, ch);
      logic [RAM_W-1:0] rgb;
      rgb = probe_mem[probe_index(x, y, z, f)];
      return rgb[RAM_W-1-COLOR_W*ch -: COLOR_W];
   endfunction

   function automatic void apply_probe_word(input pgts_req_type wd);
      int unsigned ew, eh, ed, cx, cy, cz, x1, y1, z1;
      int unsigned fx, fy, fz, gx, gy, gz, ra, rb, rc, re, lo, hi, v;
      logic [COLOR_W-1:0] shade [LANES];
      pgts_rsp_type r;
      ew = span(grid_w);
      eh = span(grid_h);
      ed = span(grid_d);
      cx = wd.pos_x >> FRAC_BITS;
      cy = wd.pos_y >> FRAC_BITS;
      cz = wd.pos_z >> FRAC_BITS;
      if (wd.opcode == OP_WRITE) begin
         if (cell_inside(cx, cy, cz) && wd.face_sel < NUM_FACES) begin
            probe_mem[probe_index(cx, cy, cz, wd.face_sel)] =
               {wd.red_in, wd.green_in, wd.blue_in};
            writes_stored++;
         end else begin
            writes_ignored++;
         end
         return;
      end
      if (!cell_inside(cx, cy, cz)) begin
         r = '0;
         r.last_face = 1'b1;
         face_color_q.insert(face_color_q.size(), r);
         samples_out++;
         return;
      end
      x1 = (cx + 1 < ew) ? cx + 1 : ew - 1;
      y1 = (cy + 1 < eh) ? cy + 1 : eh - 1;
      z1 = (cz + 1 < ed) ? cz + 1 : ed - 1;
      fx = wd.pos_x[FRAC_BITS-1:0];
      fy = wd.pos_y[FRAC_BITS-1:0];
      fz = wd.pos_z[FRAC_BITS-1:0];
      gx = ONE_FX - fx;
      gy = ONE_FX - fy;
      gz = ONE_FX - fz;
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int ch = 0; ch < LANES; ch++) begin
            ra = probe_chan(cx, cy, cz, f, ch) * gx + probe_chan(x1, cy, cz, f, ch) * fx;
            rb = probe_chan(cx, y1, cz, f, ch) * gx + probe_chan(x1, y1, cz, f, ch) * fx;
            rc = probe_chan(cx, cy, z1, f, ch) * gx + probe_chan(x1, cy, z1, f, ch) * fx;
            re = probe_chan(cx, y1, z1, f, ch) * gx + probe_chan(x1, y1, z1, f, ch) * fx;
            lo = (ra * gy + rb * fy) >> FRAC_BITS;
            hi = (rc * gy + re * fy) >> FRAC_BITS;
            v = (lo * gz + hi * fz) >> (2 * FRAC_BITS);
            if (v > COLOR_MAX) v = COLOR_MAX;
            shade[ch] = v[COLOR_W-1:0];
         end
         r.face_out  = FACE_W'(f);
         r.red_out   = shade[0];
         r.green_out = shade[1];
         r.blue_out  = shade[2];
         r.in_range  = 1'b1;
         r.last_face = (f == NUM_FACES - 1);
         face_color_q.insert(face_color_q.size(), r);
      end
      samples_in++;
   endfunction

   function automatic bit field_bad(input string tag, input logic [7:0] want_v, got_v);
      if (got_v === want_v) return 1'b0;
      $display("%0t: %s expected %0d got %0d", $time, tag, want_v, got_v);
      return 1'b1;
   endfunction

   function automatic int unsigned pick_frac();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return (1 << FRAC_BITS) - 1;
         default: return $urandom_range(0, (1 << FRAC_BITS) - 1);
      endcase
   endfunction

   function automatic int unsigned hot_cell(input int unsigned n);
      if (n == 0) return 0;
      return $urandom_range(0, 1) ? n - 1 : $urandom_range(0, n - 1);
   endfunction

   task automatic queue_write(input int unsigned px, py, pz, face, input logic [23:0] rgb);
      pgts_req_type wd;
      wd.opcode   = OP_WRITE;
      wd.pos_x    = POS_W'(px);
      wd.pos_y    = POS_W'(py);
      wd.pos_z    = POS_W'(pz);
      wd.face_sel = FACE_W'(face);
      {wd.red_in, wd.green_in, wd.blue_in} = rgb;
      if (cell_inside(wd.pos_x >> FRAC_BITS, wd.pos_y >> FRAC_BITS, wd.pos_z >> FRAC_BITS)
          && wd.face_sel < NUM_FACES)
         filled[probe_index(wd.pos_x >> FRAC_BITS, wd.pos_y >> FRAC_BITS,
                            wd.pos_z >> FRAC_BITS, wd.face_sel)] = 1'b1;
      pending_words.insert(pending_words.size(), wd);
      words_queued++;
   endtask

   // any corner face not yet written gets a random color first
   task automatic queue_sample(input int unsigned px, py, pz);
      int unsigned xs [2], ys [2], zs [2];
      pgts_req_type wd;
      xs[0] = px >> FRAC_BITS;
      ys[0] = py >> FRAC_BITS;
      zs[0] = pz >> FRAC_BITS;
      if (cell_inside(xs[0], ys[0], zs[0])) begin
         xs[1] = (xs[0] + 1 < span(grid_w)) ? xs[0] + 1 : xs[0];
         ys[1] = (ys[0] + 1 < span(grid_h)) ? ys[0] + 1 : ys[0];
         zs[1] = (zs[0] + 1 < span(grid_d)) ? zs[0] + 1 : zs[0];
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
               for (int k = 0; k < 2; k++)
                  for (int f = 0; f < NUM_FACES; f++)
                     if (!filled[probe_index(xs[i], ys[j], zs[k], f)])
                        queue_write((xs[i] << FRAC_BITS) | pick_frac(),
                                    (ys[j] << FRAC_BITS) | pick_frac(),
                                    (zs[k] << FRAC_BITS) | pick_frac(), f, 24'($urandom));
      end
      wd = {$urandom, $urandom};
      wd.opcode = OP_SAMPLE;
      wd.pos_x  = POS_W'(px);
      wd.pos_y  = POS_W'(py);
      wd.pos_z  = POS_W'(pz);
      pending_words.insert(pending_words.size(), wd);
      words_queued++;
   endtask

   task automatic queue_random_mix(input int unsigned budget);
      int unsigned hx, hy, hz, stop_at, pick, ox, oy, oz;
      hx = hot_cell(span(grid_w));
      hy = hot_cell(span(grid_h));
      hz = hot_cell(span(grid_d));
      stop_at = words_queued + budget;
      while (words_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            queue_sample((hx << FRAC_BITS) | pick_frac(), (hy << FRAC_BITS) | pick_frac(),
                         (hz << FRAC_BITS) | pick_frac());
         end else if (pick < 65) begin
            ox = (hx < MAX_DIM - 1) ? hx + $urandom_range(0, 1) : hx;
            oy = (hy < MAX_DIM - 1) ? hy + $urandom_range(0, 1) : hy;
            oz = (hz < MAX_DIM - 1) ? hz + $urandom_range(0, 1) : hz;
            queue_write((ox << FRAC_BITS) | pick_frac(), (oy << FRAC_BITS) | pick_frac(),
                        (oz << FRAC_BITS) | pick_frac(), $urandom_range(0, NUM_FACES - 1),
                        24'($urandom));
         end else if (pick < 70) begin
            queue_sample($urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095));
         end else begin
            queue_write($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 7), 24'($urandom));
         end
      end
   endtask

   task automatic set_grid_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_GRID_WIDTH:  grid_w = val;
         CSR_GRID_HEIGHT: grid_h = val;
         CSR_GRID_DEPTH:  grid_d = val;
         default: ;
      endcase
   endtask

   task automatic program_grid(input logic [DIM_W-1:0] w, h, d);
      set_grid_reg(CSR_GRID_WIDTH, w);
      set_grid_reg(CSR_GRID_HEIGHT, h);
      set_grid_reg(CSR_GRID_DEPTH, d);
   endtask

   task automatic settle();
      while (pending_words.size() != 0 || req_valid || face_color_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sender: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_words.pop_front();
            if (burst_left == 0) begin
               burst_left <= $urandom_range(0, 15);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern steps through four modes on rx_cycle, plus two long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         rx_cycle    <= 0;
         hold_left   <= 0;
         words_taken <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rsp_valid && rsp_ready) words_taken <= words_taken + 1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready && (words_taken == 40 || words_taken == 250)) begin
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode_type'(rx_cycle[8:7]))
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               RX_TOGGLE: rsp_ready <= rx_cycle[0];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) apply_probe_word(req_data);
         if (rsp_valid && rsp_ready) begin
            if (face_color_q.size() == 0) begin
               fail_count++;
               $display("%0t: result word with none expected, got %p", $time, rsp_data);
            end else begin
               face_want = face_color_q.pop_front();
               results_checked++;
               bad = field_bad("face_out", face_want.face_out, rsp_data.face_out)
                   | field_bad("red_out", face_want.red_out, rsp_data.red_out)
                   | field_bad("green_out", face_want.green_out, rsp_data.green_out)
                   | field_bad("blue_out", face_want.blue_out, rsp_data.blue_out)
                   | field_bad("in_range", face_want.in_range, rsp_data.in_range)
                   | field_bad("last_face", face_want.last_face, rsp_data.last_face);
               if (bad) fail_count++;
            end
         end
      end
   end

   always @(posedge clock)
      idle_cycles <= (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) ?
                     0 : idle_cycles + 1;

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_GRID_WIDTH;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full grid: top cell, upper neighbor clamped, ignored face codes
      for (int f = 0; f < NUM_FACES; f++)
         queue_write(12'hF00 | pick_frac(), 12'hF00 | pick_frac(), 12'hF00 | pick_frac(), f,
                     24'hFFFFFF);
      queue_sample(12'hFFF, 12'hFFF, 12'hFFF);
      queue_write(12'hF00, 12'hF00, 12'hF00, 6, 24'h000000);
      queue_write(12'hF7F, 12'hF00, 12'hF00, 7, 24'h000000);
      queue_sample(12'hF00, 12'hF00, 12'hF00);
      queue_random_mix(90);
      settle();

      // single cell grid
      program_grid(5'd1, 5'd1, 5'd1);
      for (int f = 0; f < NUM_FACES; f++)
         queue_write(0, 0, 0, f, f[0] ? 24'hFFFFFF : 24'h000000);
      queue_sample(0, 0, 0);
      queue_sample(12'h0FF, 12'h0FF, 12'h0FF);
      queue_sample(12'h100, 0, 0);
      queue_sample(0, 0, 12'hFFF);
      queue_write(12'h100, 0, 0, 0, 24'hFFFFFF);
      queue_sample(12'h080, 12'h080, 12'h080);
      queue_random_mix(30);
      settle();

      program_grid(5'd0, 5'd5, 5'd7);
      set_grid_reg(CSR_UNUSED, 5'd9);
      queue_random_mix(25);
      settle();

      program_grid(5'd31, 5'd31, 5'd31);
      queue_random_mix(90);
      settle();

      program_grid(5'd2, 5'd16, 5'd3);
      queue_random_mix(80);
      settle();

      program_grid(DIM_W'($urandom_range(1, 16)), DIM_W'($urandom_range(1, 16)),
                   DIM_W'($urandom_range(1, 16)));
      queue_random_mix(70);
      settle();

      program_grid(5'd16, 5'd1, 5'd16);
      queue_random_mix(60);
      settle();

      $display("tb: %0d samples in range, %0d out of range, %0d result words checked",
               samples_in, samples_out, results_checked);
      $display("tb: %0d probe writes stored, %0d ignored, over seven grid settings",
               writes_stored, writes_ignored);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
